>>> hw/rtl/ssfp_pkg.sv
// Shared types and constants of the servo status frame parser.
package ssfp_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 64;

    localparam logic [7:0]  HEAD_BYTE   = 8'hFF;
    localparam logic [7:0]  MIN_LENGTH  = 8'd2;
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] OUT_OK       = 2'd0;
    localparam logic [1:0] OUT_DEV_ERR  = 2'd1;
    localparam logic [1:0] OUT_OVERFLOW = 2'd2;
    localparam logic [1:0] OUT_TIMEOUT  = 2'd3;

    localparam logic [1:0] CFG_EXPECTED_ID    = 2'd0;
    localparam logic [1:0] CFG_IGNORED_STATUS = 2'd1;
    localparam logic [1:0] CFG_PARAM_CAPACITY = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd3;

    typedef struct packed {
        logic [1:0] outcome;
        logic [7:0] status;
        logic [7:0] nparam;
    } job_t;

endpackage

>>> hw/rtl/ssfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/ssfp_front.sv
// Front end: configuration registers, frame hunt, checksum and tick timeout.
module ssfp_front #(
    parameter int PAYLOAD_DEPTH = ssfp_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [1:0]                       s_tuser,
    input  logic [7:0]                       s_tdata,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_addr,
    input  logic [15:0]                      cfg_wdata,
    input  logic                             q_full,
    input  logic                             emit_pending,
    output logic                             push,
    output ssfp_pkg::job_t                   push_job,
    output logic                             ram_we,
    output logic [$clog2(PAYLOAD_DEPTH)-1:0] ram_waddr,
    output logic [7:0]                       ram_wdata
);
    import ssfp_pkg::*;

    localparam int AW = $clog2(PAYLOAD_DEPTH);
    localparam logic [8:0] DEPTH9 = 9'(PAYLOAD_DEPTH);

    localparam logic [2:0] PH_HEAD0   = 3'd0;
    localparam logic [2:0] PH_HEAD1   = 3'd1;
    localparam logic [2:0] PH_ID      = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;

    logic [7:0]  expected_id_reg;
    logic [7:0]  ignored_status_reg;
    logic [5:0]  param_capacity_reg;
    logic [15:0] timeout_ticks_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  frame_id_reg, frame_id_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  status_reg, status_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic        waiting_reg, waiting_next;

    logic        accept;
    logic [1:0]  cmd;
    logic [7:0]  data;
    logic [7:0]  sum_add;
    logic [16:0] elapsed_inc;
    logic [7:0]  nparam;
    logic        frame_ok;

    assign s_tready = !q_full && !(phase_reg == PH_PAYLOAD && emit_pending);
    assign accept   = s_tvalid && s_tready;
    assign cmd      = s_tuser;
    assign data     = s_tdata;
    assign sum_add  = sum_reg + data;
    assign nparam   = frame_length_reg - MIN_LENGTH;
    assign elapsed_inc = (elapsed_reg != ELAPSED_MAX) ? elapsed_reg + 17'd1 : elapsed_reg;
    assign frame_ok = (data == ~sum_reg) && (frame_id_reg == expected_id_reg)
                      && !(ignored_status_reg != 8'd0 && status_reg == ignored_status_reg);

    assign ram_we    = accept && waiting_reg && cmd == CMD_BYTE && phase_reg == PH_PAYLOAD;
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = data;

    always_comb begin
        phase_next        = phase_reg;
        frame_id_next     = frame_id_reg;
        frame_length_next = frame_length_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        status_next       = status_reg;
        elapsed_next      = elapsed_reg;
        waiting_next      = waiting_reg;
        push              = 1'b0;
        push_job.outcome  = OUT_OK;
        push_job.status   = 8'd0;
        push_job.nparam   = 8'd0;
        if (accept) begin
            if (cmd == CMD_START) begin
                phase_next        = PH_HEAD0;
                frame_id_next     = 8'd0;
                frame_length_next = 8'd0;
                count_next        = 8'd0;
                sum_next          = 8'd0;
                elapsed_next      = 17'd0;
                waiting_next      = 1'b1;
            end else if (waiting_reg && cmd == CMD_TICK) begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc > {1'b0, timeout_ticks_reg}) begin
                    waiting_next     = 1'b0;
                    push             = 1'b1;
                    push_job.outcome = OUT_TIMEOUT;
                end
            end else if (waiting_reg && cmd == CMD_BYTE) begin
                unique case (phase_reg)
                    PH_HEAD0: begin
                        if (data == HEAD_BYTE) begin
                            phase_next = PH_HEAD1;
                        end
                    end
                    PH_HEAD1: begin
                        phase_next = (data == HEAD_BYTE) ? PH_ID : PH_HEAD0;
                    end
                    PH_ID: begin
                        frame_id_next = data;
                        sum_next      = data;
                        phase_next    = PH_LEN;
                    end
                    PH_LEN: begin
                        frame_length_next = data;
                        sum_next          = sum_add;
                        count_next        = 8'd0;
                        if (data < MIN_LENGTH || ({1'b0, data} - 9'd1) > DEPTH9) begin
                            phase_next = PH_HEAD0;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (count_reg == 8'd0) begin
                            status_next = data;
                        end
                        sum_next   = sum_add;
                        count_next = count_reg + 8'd1;
                        if (({1'b0, count_reg} + 9'd2) >= {1'b0, frame_length_reg}) begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        phase_next = PH_HEAD0;
                        if (frame_ok) begin
                            waiting_next    = 1'b0;
                            push            = 1'b1;
                            push_job.nparam = nparam;
                            if (status_reg != 8'd0) begin
                                push_job.outcome = OUT_DEV_ERR;
                                push_job.status  = status_reg;
                            end else if (nparam > {2'b00, param_capacity_reg}) begin
                                push_job.outcome = OUT_OVERFLOW;
                            end else begin
                                push_job.outcome = OUT_OK;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_HEAD0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_id_reg    <= 8'd0;
            ignored_status_reg <= 8'd0;
            param_capacity_reg <= 6'd63;
            timeout_ticks_reg  <= 16'd100;
            phase_reg          <= PH_HEAD0;
            frame_id_reg       <= 8'd0;
            frame_length_reg   <= 8'd0;
            count_reg          <= 8'd0;
            sum_reg            <= 8'd0;
            elapsed_reg        <= 17'd0;
            waiting_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_EXPECTED_ID:    expected_id_reg    <= cfg_wdata[7:0];
                    CFG_IGNORED_STATUS: ignored_status_reg <= cfg_wdata[7:0];
                    CFG_PARAM_CAPACITY: param_capacity_reg <= cfg_wdata[5:0];
                    CFG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            phase_reg        <= phase_next;
            frame_id_reg     <= frame_id_next;
            frame_length_reg <= frame_length_next;
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            elapsed_reg      <= elapsed_next;
            waiting_reg      <= waiting_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
    end

endmodule

>>> hw/rtl/ssfp_queue.sv
// Two-entry job queue between the front end and the back end.
module ssfp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ssfp_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output ssfp_pkg::job_t pop_job
);
    import ssfp_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full    = fill_reg == 2'd2;
    assign valid   = fill_reg != 2'd0;
    assign pop_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

>>> hw/rtl/ssfp_back.sv
// Back end: turns queued jobs into result transfers, reading parameters from RAM.
module ssfp_back #(
    parameter int PAYLOAD_DEPTH = ssfp_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  ssfp_pkg::job_t                   q_job,
    output logic                             q_pop,
    output logic                             busy,
    output logic                             ram_re,
    output logic [$clog2(PAYLOAD_DEPTH)-1:0] ram_raddr,
    input  logic [7:0]                       ram_rdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,
    output logic [2:0]                       m_tuser,
    output logic                             m_tlast
);
    import ssfp_pkg::*;

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_LOAD = 2'd2;
    localparam logic [1:0] B_HOLD = 2'd3;

    logic [1:0]    state_reg;
    logic [AW-1:0] addr_reg;
    logic [5:0]    remain_reg;
    logic [5:0]    total_reg;

    logic          out_valid_reg;
    logic [1:0]    out_outcome_reg;
    logic [7:0]    out_byte_reg;
    logic          out_bvalid_reg;
    logic [5:0]    out_count_reg;
    logic [7:0]    out_status_reg;
    logic          out_last_reg;

    assign busy      = state_reg != B_IDLE;
    assign q_pop     = state_reg == B_IDLE && q_valid;
    assign ram_re    = state_reg == B_READ;
    assign ram_raddr = addr_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_status_reg, out_count_reg, out_byte_reg};
    assign m_tuser  = {out_bvalid_reg, out_outcome_reg};
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        if (q_job.outcome == OUT_OK && q_job.nparam != 8'd0) begin
                            addr_reg   <= AW'(1);
                            remain_reg <= q_job.nparam[5:0];
                            total_reg  <= q_job.nparam[5:0];
                            state_reg  <= B_READ;
                        end else begin
                            out_outcome_reg <= q_job.outcome;
                            out_byte_reg    <= 8'd0;
                            out_bvalid_reg  <= 1'b0;
                            out_count_reg   <= (q_job.outcome == OUT_OVERFLOW)
                                               ? q_job.nparam[5:0] : 6'd0;
                            out_status_reg  <= q_job.status;
                            out_last_reg    <= 1'b1;
                            out_valid_reg   <= 1'b1;
                            state_reg       <= B_HOLD;
                        end
                    end
                end
                B_READ: begin
                    state_reg <= B_LOAD;
                end
                B_LOAD: begin
                    out_outcome_reg <= OUT_OK;
                    out_byte_reg    <= ram_rdata;
                    out_bvalid_reg  <= 1'b1;
                    out_count_reg   <= total_reg;
                    out_status_reg  <= 8'd0;
                    out_last_reg    <= remain_reg == 6'd1;
                    out_valid_reg   <= 1'b1;
                    state_reg       <= B_HOLD;
                end
                B_HOLD: begin
                    if (m_tready) begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg) begin
                            state_reg <= B_IDLE;
                        end else begin
                            addr_reg   <= addr_reg + AW'(1);
                            remain_reg <= remain_reg - 6'd1;
                            state_reg  <= B_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/servo_status_frame_parser.sv
// Top level of the servo status frame parser.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tuser: cmd; tdata: rx_byte
//  m_       out  m_tvalid/m_tready  tuser: outcome, byte_valid; tdata: byte, count, status
//  cfg_     in   cfg_we             cfg_addr selects register, cfg_wdata value
//
// Input transfers are taken one per cycle while s_tready is high; the front end finishes each in that cycle.
// s_tready drops while the job queue is full, or while the hunt is in the payload
// phase and the back end still holds or emits results of an earlier wait.
// m_tvalid is raised by the back end's output register once the job has passed the
// job queue, and for a frame with parameters also after the RAM read and output load;
// each further parameter byte takes a RAM read, an output load and a handshake.
// Reset is synchronous; the payload RAM needs no clearing.
module servo_status_frame_parser #(
    parameter int PAYLOAD_DEPTH = ssfp_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] param_byte, [13:8] param_count, [21:14] servo_status
    output logic [2:0]  m_tuser,   // [1:0] outcome, [2] byte_valid
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import ssfp_pkg::*;

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          push;
    job_t          push_job;
    job_t          q_job;
    logic          back_busy;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    ssfp_front #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .q_full       (q_full),
        .emit_pending (q_valid || back_busy),
        .push         (push),
        .push_job     (push_job),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata)
    );

    ssfp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_job  (q_job)
    );

    ssfp_ram #(
        .WIDTH(8),
        .DEPTH(PAYLOAD_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ssfp_back #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .busy      (back_busy),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> dv/tb_servo_status_frame_parser.sv
// Self-checking testbench for the servo status frame parser, with a frame-level predictor.
module tb_servo_status_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import ssfp_pkg::*;

    localparam int         DEPTH        = PAYLOAD_DEPTH_DEF;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         QUIET_LIMIT  = 4000;
    localparam int         PHASE_ITEMS  = 15;

    typedef enum logic [2:0] {
        HUNT_HEAD0, HUNT_HEAD1, HUNT_ID, HUNT_LEN, HUNT_PAYLOAD, HUNT_CHECK
    } hunt_e;

    typedef struct packed {
        logic [1:0] outcome;
        logic [7:0] pbyte;
        logic       valid;
        logic [5:0] count;
        logic [7:0] status;
        logic       last;
    } reply_t;

    class StatusFrameScoreboard;
        logic [7:0]  want_id;
        logic [7:0]  skip_status;
        logic [5:0]  capacity;
        logic [15:0] tick_limit;

        hunt_e       hunt;
        logic [7:0]  frm_id;
        logic [7:0]  frm_len;
        logic [7:0]  sum;
        logic [7:0]  payload [DEPTH];
        int          pay_cnt;
        logic [16:0] ticks;
        bit          armed;

        reply_t      replies[$];
        int          errors;

        function new();
            want_id     = 8'd0;
            skip_status = 8'd0;
            capacity    = 6'd63;
            tick_limit  = 16'd100;
            clear_parser();
            ticks       = '0;
            armed       = 1'b0;
            errors      = 0;
        endfunction

        function void clear_parser();
            hunt    = HUNT_HEAD0;
            frm_id  = 8'd0;
            frm_len = 8'd0;
            pay_cnt = 0;
            sum     = 8'd0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] v);
            case (idx)
                CFG_EXPECTED_ID:    want_id     = v[7:0];
                CFG_IGNORED_STATUS: skip_status = v[7:0];
                CFG_PARAM_CAPACITY: capacity    = v[5:0];
                CFG_TIMEOUT_TICKS:  tick_limit  = v;
                default: ;
            endcase
        endfunction

        function void push_reply(logic [1:0] outcome, logic [7:0] pbyte, logic valid,
                                 logic [5:0] count, logic [7:0] status, logic last);
            reply_t r;
            r = '{outcome: outcome, pbyte: pbyte, valid: valid, count: count,
                  status: status, last: last};
            replies.push_back(r);
        endfunction

        function int pending();
            return replies.size();
        endfunction

        function string show_reply(reply_t r);
            return $sformatf(
                "outcome=%0d byte=%02h valid=%0d count=%0d status=%02h last=%0d",
                r.outcome, r.pbyte, r.valid, r.count, r.status, r.last);
        endfunction

        function void note_input(logic [1:0] cmd, logic [7:0] data);
            logic [7:0] status;
            int         nparam;
            if (cmd == CMD_START) begin
                clear_parser();
                ticks = '0;
                armed = 1'b1;
            end else if (armed && cmd == CMD_TICK) begin
                if (ticks != ELAPSED_MAX) ticks++;
                if (ticks > {1'b0, tick_limit}) begin
                    armed = 1'b0;
                    push_reply(OUT_TIMEOUT, 8'd0, 1'b0, 6'd0, 8'd0, 1'b1);
                end
            end else if (armed && cmd == CMD_BYTE) begin
                case (hunt)
                    HUNT_HEAD0: if (data == HEAD_BYTE) hunt = HUNT_HEAD1;
                    HUNT_HEAD1: hunt = (data == HEAD_BYTE) ? HUNT_ID : HUNT_HEAD0;
                    HUNT_ID: begin
                        frm_id = data;
                        sum    = data;
                        hunt   = HUNT_LEN;
                    end
                    HUNT_LEN: begin
                        frm_len = data;
                        sum     = sum + data;
                        pay_cnt = 0;
                        if (data < MIN_LENGTH || int'(data) - 1 > DEPTH) hunt = HUNT_HEAD0;
                        else hunt = HUNT_PAYLOAD;
                    end
                    HUNT_PAYLOAD: begin
                        if (pay_cnt < DEPTH) payload[pay_cnt] = data;
                        sum = sum + data;
                        pay_cnt++;
                        if (pay_cnt >= int'(frm_len) - 1) hunt = HUNT_CHECK;
                    end
                    HUNT_CHECK: begin
                        hunt   = HUNT_HEAD0;
                        status = payload[0];
                        nparam = int'(frm_len) - 2;
                        // good checksum, our ID, and not our own echo
                        if (data == ~sum && frm_id == want_id &&
                            !(skip_status != 8'd0 && status == skip_status)) begin
                            armed = 1'b0;
                            if (status != 8'd0)
                                push_reply(OUT_DEV_ERR, 8'd0, 1'b0, 6'd0, status, 1'b1);
                            else if (nparam > capacity)
                                push_reply(OUT_OVERFLOW, 8'd0, 1'b0, 6'(nparam), 8'd0, 1'b1);
                            else if (nparam == 0)
                                push_reply(OUT_OK, 8'd0, 1'b0, 6'd0, 8'd0, 1'b1);
                            else
                                for (int i = 0; i < nparam; i++)
                                    push_reply(OUT_OK, payload[1 + i], 1'b1, 6'(nparam),
                                               8'd0, i == nparam - 1);
                        end
                    end
                    default: hunt = HUNT_HEAD0;
                endcase
            end
        endfunction

        function void check_result(logic [23:0] tdata, logic [2:0] tuser, logic tlast);
            reply_t got;
            reply_t want;
            got = '{outcome: tuser[1:0], pbyte: tdata[7:0], valid: tuser[2],
                    count: tdata[13:8], status: tdata[21:14], last: tlast};
            if (replies.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: %s", show_reply(got));
                return;
            end
            want = replies.pop_front();
            if (got != want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %s | got %s", show_reply(want), show_reply(got));
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // [7:0] rx_byte
    logic [1:0]  s_tuser   = 2'd0;   // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;            // [7:0] param_byte, [13:8] param_count, [21:14] servo_status
    logic [2:0]  m_tuser;            // [1:0] outcome, [2] byte_valid
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = 2'd0;
    logic [15:0] cfg_wdata = 16'd0;

    StatusFrameScoreboard sb;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          tick_pct      = 0;
    int          items_sent    = 0;
    int          quiet_cycles  = 0;
    logic [7:0]  cur_id        = 8'd0;
    logic [7:0]  cur_ignored   = 8'd0;
    logic [15:0] cur_tmo       = 16'd100;

    servo_status_frame_parser #(.PAYLOAD_DEPTH(DEPTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // transfer monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("tb_servo_status_frame_parser: done, errors");
                    $finish;
                end
            end
        end
    end

    task automatic send(input logic [1:0] cmd, input logic [7:0] data);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic rx(input logic [7:0] b);
        send(CMD_BYTE, b);
        if ($urandom_range(99) < tick_pct) send(CMD_TICK, 8'($urandom));
    endtask

    task automatic send_frame(input logic [7:0] id, input logic [7:0] status,
                              input int nparam, input bit corrupt);
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        len = 8'(nparam + 2);
        sum = id + len + status;
        rx(HEAD_BYTE);
        rx(HEAD_BYTE);
        rx(id);
        rx(len);
        rx(status);
        repeat (nparam) begin
            b   = 8'($urandom);
            sum = sum + b;
            rx(b);
        end
        rx(corrupt ? (~sum ^ 8'($urandom_range(1, 255))) : ~sum);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_reg(addr, value);
    endtask

    task automatic program_regs(input logic [7:0] id, input logic [7:0] ignored,
                                input logic [5:0] cap, input logic [15:0] tmo);
        write_reg(CFG_EXPECTED_ID, {8'd0, id});
        write_reg(CFG_IGNORED_STATUS, {8'd0, ignored});
        write_reg(CFG_PARAM_CAPACITY, {10'd0, cap});
        write_reg(CFG_TIMEOUT_TICKS, tmo);
        cfg_we      <= 1'b0;
        cur_id      = id;
        cur_ignored = ignored;
        cur_tmo     = tmo;
    endtask

    function automatic int pick_nparam();
        if ($urandom_range(11) == 0) return $urandom_range(16, 63);
        return $urandom_range(0, 6);
    endfunction

    task automatic random_wait();
        send(CMD_START, 8'($urandom));
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(9))
                0, 1, 2, 3: send_frame(cur_id, 8'd0, pick_nparam(), 1'b0);
                4: send_frame(cur_id, 8'($urandom_range(1, 255)), pick_nparam(), 1'b0);
                5: send_frame(cur_id, cur_ignored, pick_nparam(), 1'b0);
                6: send_frame(cur_id ^ 8'($urandom_range(1, 255)), 8'($urandom_range(0, 3)),
                              pick_nparam(), 1'b0);
                7: send_frame(cur_id, 8'd0, pick_nparam(), 1'b1);
                8: begin
                    rx(HEAD_BYTE);
                    rx(HEAD_BYTE);
                    rx(cur_id);
                    rx($urandom_range(1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(66, 255)));
                end
                default: begin
                    rx(HEAD_BYTE);
                    rx(8'($urandom_range(0, 254)));
                    send(CMD_UNUSED, 8'($urandom));
                    repeat ($urandom_range(0, 3)) rx(8'($urandom));
                    if ($urandom_range(3) == 0) send(CMD_START, 8'($urandom));
                end
            endcase
        end
        if ($urandom_range(99) < 40 && cur_tmo < 16)
            repeat (int'(cur_tmo) + 2) send(CMD_TICK, 8'($urandom));
    endtask

    initial begin
        int stop;
        sb = new();
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle block ignores everything but start
        send(CMD_BYTE, HEAD_BYTE);
        send(CMD_TICK, 8'h00);
        send(CMD_UNUSED, 8'hA5);
        // reset settings: ID 0, full capacity
        send(CMD_START, 8'h00);
        send_frame(8'h00, 8'h00, 63, 1'b0);
        settle();

        program_regs(8'h5A, 8'h20, 6'd4, 16'd3);
        send(CMD_START, 8'hFF);
        send_frame(8'h5B, 8'h00, 1, 1'b0);
        send_frame(8'h5A, 8'h20, 1, 1'b0);
        send_frame(8'h5A, 8'h00, 1, 1'b1);
        rx(HEAD_BYTE);
        rx(HEAD_BYTE);
        rx(8'h5A);
        rx(8'h01);
        rx(HEAD_BYTE);
        rx(8'h00);
        send_frame(8'h5A, 8'h00, 0, 1'b0);
        send(CMD_START, 8'h00);
        send_frame(8'h5A, 8'h80, 5, 1'b0);
        send(CMD_START, 8'h00);
        send_frame(8'h5A, 8'h00, 5, 1'b0);
        send(CMD_START, 8'h00);
        send(CMD_TICK, 8'h00);
        send(CMD_START, 8'h00);
        repeat (4) send(CMD_TICK, 8'hFF);
        send(CMD_START, 8'h00);
        rx(HEAD_BYTE);
        rx(HEAD_BYTE);
        rx(8'h5A);
        rx(8'd66);
        send_frame(8'h5A, 8'h00, 4, 1'b0);

        stop = items_sent;
        for (int p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    program_regs(8'($urandom), 8'h00, 6'd63, 16'hFFFF);
                end
                1: begin
                    send_idle_pct = 85;
                    stall_pct     = 0;
                    program_regs(8'h00, 8'hFF, 6'd0, 16'd0);
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 85;
                    program_regs(8'hFF, 8'($urandom_range(1, 254)), 6'($urandom_range(1, 62)),
                                 16'($urandom_range(1, 8)));
                end
                default: begin
                    send_idle_pct = 11;
                    stall_pct     = 11;
                    program_regs(8'($urandom), 8'($urandom), 6'($urandom),
                                 16'($urandom_range(0, 5)));
                end
            endcase
            tick_pct = 8;
            stop     = stop + PHASE_ITEMS;
            while (items_sent < stop) random_wait();
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_servo_status_frame_parser: done, clean");
        else
            $display("tb_servo_status_frame_parser: done, errors");
        $finish;
    end

endmodule
